### rtl/core/scc_pkg.sv
package scc_pkg;

  // Default fixed-point format: signed Q15.16 coordinates
  localparam int SCC_FRAC_BITS   = 16;
  localparam int SCC_COORD_WIDTH = 32;

  // Result flag positions in the output tuser
  localparam int SCC_USER_CONTACT = 0;
  localparam int SCC_USER_SWAPPED = 1;
  localparam int SCC_USER_DEGEN   = 2;
  localparam int SCC_USER_W       = 3;

  // Valid and enable that every pipeline step sees
  typedef struct packed {
    logic en;
    logic vld;
  } scc_step_ctl_t;

endpackage

### rtl/core/scc_sqrt_step.sv
// One bit of the digit-by-digit integer square root
module scc_sqrt_step import scc_pkg::*; #(
  parameter int LEN_W  = 64,
  parameter int ROOT_W = 31,
  parameter int K      = 0,
  parameter int SB_W   = 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  scc_step_ctl_t     ctl_i,
  input  logic [LEN_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  input  logic [SB_W-1:0]   sb_i,
  output logic              vld_o,
  output logic [LEN_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o,
  output logic [SB_W-1:0]   sb_o
);

  logic [LEN_W-1:0]  trial;
  logic              fits;
  logic              vld_q;
  logic [LEN_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [SB_W-1:0]   sb_q;

  // (root + 2^K)^2 - root^2 = root * 2^(K+1) + 2^(2K)
  assign trial = (LEN_W'(root_i) << (K + 1)) | (LEN_W'(1) << (2 * K));
  assign fits  = rem_i >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      rem_q  <= fits ? rem_i - trial : rem_i;
      root_q <= fits ? (root_i | (ROOT_W'(1) << K)) : root_i;
      sb_q   <= sb_i;
    end
  end

  assign vld_o  = vld_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign sb_o   = sb_q;

endmodule

### rtl/core/scc_div_step.sv
// One quotient bit of the restoring divide, three lanes sharing a divisor
module scc_div_step import scc_pkg::*; #(
  parameter int DW   = 31,
  parameter int QW   = 16,
  parameter int SB_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scc_step_ctl_t       ctl_i,
  input  logic [DW-1:0]       dist_i,
  input  logic [2:0][DW-1:0]  rem_i,
  input  logic [2:0][QW-1:0]  q_i,
  input  logic [SB_W-1:0]     sb_i,
  output logic                vld_o,
  output logic [DW-1:0]       dist_o,
  output logic [2:0][DW-1:0]  rem_o,
  output logic [2:0][QW-1:0]  q_o,
  output logic [SB_W-1:0]     sb_o
);

  logic [2:0][DW:0]   shifted;
  logic [2:0]         take;
  logic [2:0][DW-1:0] rem_d;
  logic [2:0][QW-1:0] q_d;
  logic               vld_q;
  logic [DW-1:0]      dist_q;
  logic [2:0][DW-1:0] rem_q;
  logic [2:0][QW-1:0] q_q;
  logic [SB_W-1:0]    sb_q;

  // remainder stays below the divisor, so the difference fits DW bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      shifted[i] = {rem_i[i], 1'b0};
      take[i]    = shifted[i] >= {1'b0, dist_i};
      rem_d[i]   = take[i] ? DW'(shifted[i] - {1'b0, dist_i}) : shifted[i][DW-1:0];
      q_d[i]     = {q_i[i][QW-2:0], take[i]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (ctl_i.en) begin
      vld_q <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      dist_q <= dist_i;
      rem_q  <= rem_d;
      q_q    <= q_d;
      sb_q   <= sb_i;
    end
  end

  assign vld_o  = vld_q;
  assign dist_o = dist_q;
  assign rem_o  = rem_q;
  assign q_o    = q_q;
  assign sb_o   = sb_q;

endmodule

### rtl/core/scc_skid.sv
// Two-entry output buffer; full freezes the whole pipeline
module scc_skid import scc_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] data_i,
  output logic         full_o,
  output logic         valid_o,
  input  logic         ready_i,
  output logic [W-1:0] data_o
);

  logic [1:0]   cnt_q, cnt_d;
  logic [W-1:0] e0_q, e0_d;
  logic [W-1:0] e1_q, e1_d;
  logic         pop;

  assign pop = (cnt_q != 2'd0) && ready_i;

  // entry and count update
  always_comb begin
    cnt_d = cnt_q;
    e0_d  = e0_q;
    e1_d  = e1_q;
    unique case ({push_i, pop})
      2'b10: begin
        cnt_d = cnt_q + 2'd1;
        if (cnt_q == 2'd0) begin
          e0_d = data_i;
        end else begin
          e1_d = data_i;
        end
      end
      2'b01: begin
        cnt_d = cnt_q - 2'd1;
        e0_d  = e1_q;
      end
      2'b11: begin
        if (cnt_q == 2'd1) begin
          e0_d = data_i;
        end else begin
          e0_d = e1_q;
          e1_d = data_i;
        end
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q <= e0_d;
    e1_q <= e1_d;
  end

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = e0_q;

endmodule

### rtl/core/sphere_sphere_contact_unit.sv
// Sphere-sphere narrow-phase contact test (default Q15.16 format). Takes one
// sphere pair per cycle while the output buffer is not full and returns one
// result per pair, in order. Most of the pipeline is the square root of the
// squared center distance, one root bit per stage, followed by the normal
// divide, one quotient bit per stage. The whole pipeline holds when its
// two-entry output buffer is full, so input ready drops only after two
// results wait untaken; nothing is dropped or repeated on a stall.
module sphere_sphere_contact_unit import scc_pkg::*; #(
  parameter int   FRAC_BITS   = SCC_FRAC_BITS,
  parameter int   COORD_WIDTH = SCC_COORD_WIDTH,
  localparam int  IN_TW  = ((8 * COORD_WIDTH - 4 + 7) / 8) * 8,
  localparam int  OUT_TW = ((3 * (FRAC_BITS + 2) + 4 * COORD_WIDTH - 1 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // first center x, y, z, first radius, second center x, y, z, second radius
  input  logic [IN_TW-1:0]      s_axis_tdata_i,
  // first_has_body
  input  logic                  s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // normal x, y, z, penetration_depth, point x, y, z
  output logic [OUT_TW-1:0]     m_axis_tdata_o,
  // contact_found, roles_swapped, degenerate
  output logic [SCC_USER_W-1:0] m_axis_tuser_o
);

  localparam int CW     = COORD_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int RW     = CW - 2;
  localparam int SW     = CW - 1;
  localparam int MW     = CW - 1;
  localparam int DW     = CW + 1;
  localparam int SQW    = 2 * MW;
  localparam int LEN_W  = 2 * CW;
  localparam int NW     = FB + 2;
  localparam int PW     = CW - 1;
  localparam int PRW    = FB + 1 + RW;
  localparam int SPH    = 4 * CW - 2;
  localparam int SQ_N   = MW;
  localparam int CR_W   = 3 * MW + 3 + 3 * CW + RW + SW + 1;
  localparam int SQ_SBW = CR_W + 2;
  localparam int DV_SBW = 6 + 3 * CW + RW + PW + 3;
  localparam int OUT_RAW = 3 * NW + PW + 3 * CW;
  localparam int SK_W   = OUT_TW + SCC_USER_W;

  logic adv;
  logic full;

  // ---------------- stage A: role swap, differences, radius sum
  logic [2:0][CW-1:0] fa_c, sa_c, in_p1, in_p2;
  logic [RW-1:0]      fa_r, sa_r, in_r1, in_r2;
  logic               in_swap;

  logic               a_vld_q;
  logic [2:0][CW-1:0] a_p1_q;
  logic [2:0][DW-1:0] a_d_q;
  logic [RW-1:0]      a_r1_q;
  logic [SW-1:0]      a_sum_q;
  logic               a_swap_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa_c[i] = s_axis_tdata_i[i*CW +: CW];
      sa_c[i] = s_axis_tdata_i[SPH + i*CW +: CW];
    end
    fa_r    = s_axis_tdata_i[3*CW +: RW];
    sa_r    = s_axis_tdata_i[SPH + 3*CW +: RW];
    in_swap = ~s_axis_tuser_i;
    in_p1   = in_swap ? sa_c : fa_c;
    in_p2   = in_swap ? fa_c : sa_c;
    in_r1   = in_swap ? sa_r : fa_r;
    in_r2   = in_swap ? fa_r : sa_r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        a_d_q[i] <= {in_p1[i][CW-1], in_p1[i]} - {in_p2[i][CW-1], in_p2[i]};
      end
      a_p1_q   <= in_p1;
      a_r1_q   <= in_r1;
      a_sum_q  <= SW'(in_r1) + SW'(in_r2);
      a_swap_q <= in_swap;
    end
  end

  // ---------------- stage B: magnitudes and per-axis early reject
  logic [2:0][DW-1:0] mag_w;
  logic [2:0]         near_w;

  logic               b_vld_q;
  logic [2:0][MW-1:0] b_mag_q;
  logic [2:0]         b_neg_q;
  logic               b_near_q;
  logic [2:0][CW-1:0] b_p1_q;
  logic [RW-1:0]      b_r1_q;
  logic [SW-1:0]      b_sum_q;
  logic               b_swap_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_w[i]  = a_d_q[i][DW-1] ? DW'(-a_d_q[i]) : a_d_q[i];
      near_w[i] = mag_w[i] <= DW'(a_sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_vld_q <= 1'b0;
    end else if (adv) begin
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_mag_q[i] <= mag_w[i][MW-1:0];
        b_neg_q[i] <= a_d_q[i][DW-1];
      end
      b_near_q <= &near_w;
      b_p1_q   <= a_p1_q;
      b_r1_q   <= a_r1_q;
      b_sum_q  <= a_sum_q;
      b_swap_q <= a_swap_q;
    end
  end

  // ---------------- stage C: squares
  logic                c_vld_q;
  logic [2:0][SQW-1:0] c_sq_q;
  logic [SQW-1:0]      c_ss_q;
  logic                c_near_q;
  logic [CR_W-1:0]     c_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_vld_q <= 1'b0;
    end else if (adv) begin
      c_vld_q <= b_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_sq_q[i] <= b_mag_q[i] * b_mag_q[i];
      end
      c_ss_q   <= b_sum_q * b_sum_q;
      c_near_q <= b_near_q;
      c_cr_q   <= {b_mag_q, b_neg_q, b_p1_q, b_r1_q, b_sum_q, b_swap_q};
    end
  end

  // ---------------- stage D: squared length
  logic             d_vld_q;
  logic [LEN_W-1:0] d_len_q;
  logic [SQW-1:0]   d_ss_q;
  logic             d_near_q;
  logic [CR_W-1:0]  d_cr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_vld_q <= 1'b0;
    end else if (adv) begin
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d_len_q  <= LEN_W'(c_sq_q[0]) + LEN_W'(c_sq_q[1]) + LEN_W'(c_sq_q[2]);
      d_ss_q   <= c_ss_q;
      d_near_q <= c_near_q;
      d_cr_q   <= c_cr_q;
    end
  end

  // ---------------- stage E: contact and degenerate decision
  logic             e_vld_q;
  logic [LEN_W-1:0] e_len_q;
  logic [SQ_SBW-1:0] e_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_vld_q <= 1'b0;
    end else if (adv) begin
      e_vld_q <= d_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      e_len_q <= d_len_q;
      e_sb_q  <= {d_cr_q, d_near_q && (d_len_q <= LEN_W'(d_ss_q)), d_len_q == '0};
    end
  end

  // ---------------- square root, one root bit per stage
  logic [SQ_N:0]             sq_vld;
  logic [SQ_N:0][LEN_W-1:0]  sq_rem;
  logic [SQ_N:0][MW-1:0]     sq_root;
  logic [SQ_N:0][SQ_SBW-1:0] sq_sb;

  assign sq_vld[0]  = e_vld_q;
  assign sq_rem[0]  = e_len_q;
  assign sq_root[0] = '0;
  assign sq_sb[0]   = e_sb_q;

  for (genvar j = 0; j < SQ_N; j++) begin : g_sqrt
    scc_step_ctl_t ctl;
    assign ctl = '{en: adv, vld: sq_vld[j]};
    scc_sqrt_step #(
      .LEN_W (LEN_W),
      .ROOT_W(MW),
      .K     (SQ_N - 1 - j),
      .SB_W  (SQ_SBW)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .rem_i (sq_rem[j]),
      .root_i(sq_root[j]),
      .sb_i  (sq_sb[j]),
      .vld_o (sq_vld[j+1]),
      .rem_o (sq_rem[j+1]),
      .root_o(sq_root[j+1]),
      .sb_o  (sq_sb[j+1])
    );
  end

  // ---------------- stage G: penetration and divide setup
  logic [2:0][MW-1:0] g_mag;
  logic [2:0]         g_neg;
  logic [2:0][CW-1:0] g_p1;
  logic [RW-1:0]      g_r1;
  logic [SW-1:0]      g_sum;
  logic               g_swap, g_contact, g_degen;
  logic [MW-1:0]      g_dist;
  logic [2:0]         g_ge;
  logic [2:0][MW-1:0] g_rem;

  assign {g_mag, g_neg, g_p1, g_r1, g_sum, g_swap, g_contact, g_degen} = sq_sb[SQ_N];
  assign g_dist = sq_root[SQ_N];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      g_ge[i]  = g_mag[i] >= g_dist;
      g_rem[i] = g_ge[i] ? '0 : g_mag[i];
    end
  end

  logic [FB:0]                dv_vld;
  logic [FB:0][MW-1:0]        dv_dist;
  logic [FB:0][2:0][MW-1:0]   dv_rem;
  logic [FB:0][2:0][FB-1:0]   dv_q;
  logic [FB:0][DV_SBW-1:0]    dv_sb;

  logic                g_vld_q;
  logic [MW-1:0]       g_dist_q;
  logic [2:0][MW-1:0]  g_rem_q;
  logic [DV_SBW-1:0]   g_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_vld_q <= 1'b0;
    end else if (adv) begin
      g_vld_q <= sq_vld[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_dist_q <= g_dist;
      g_rem_q  <= g_rem;
      g_sb_q   <= {g_ge, g_neg, g_p1, g_r1, PW'(g_sum - g_dist), g_swap, g_contact, g_degen};
    end
  end

  assign dv_vld[0]  = g_vld_q;
  assign dv_dist[0] = g_dist_q;
  assign dv_rem[0]  = g_rem_q;
  assign dv_q[0]    = '0;
  assign dv_sb[0]   = g_sb_q;

  // ---------------- normal divide, one quotient bit per stage
  for (genvar j = 0; j < FB; j++) begin : g_div
    scc_step_ctl_t ctl;
    assign ctl = '{en: adv, vld: dv_vld[j]};
    scc_div_step #(
      .DW  (MW),
      .QW  (FB),
      .SB_W(DV_SBW)
    ) u_step (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .dist_i(dv_dist[j]),
      .rem_i (dv_rem[j]),
      .q_i   (dv_q[j]),
      .sb_i  (dv_sb[j]),
      .vld_o (dv_vld[j+1]),
      .dist_o(dv_dist[j+1]),
      .rem_o (dv_rem[j+1]),
      .q_o   (dv_q[j+1]),
      .sb_o  (dv_sb[j+1])
    );
  end

  // ---------------- stage F1: normal magnitude and lever product
  logic [2:0]         h_ge, h_neg;
  logic [2:0][CW-1:0] h_p1;
  logic [RW-1:0]      h_r1;
  logic [PW-1:0]      h_pen;
  logic               h_swap, h_contact, h_degen;
  logic [2:0][FB:0]   h_nmag;

  assign {h_ge, h_neg, h_p1, h_r1, h_pen, h_swap, h_contact, h_degen} = dv_sb[FB];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (h_degen) begin
        h_nmag[i] = '0;
      end else if (h_ge[i]) begin
        h_nmag[i] = (FB+1)'(1) << FB;
      end else begin
        h_nmag[i] = {1'b0, dv_q[FB][i]};
      end
    end
  end

  logic                f_vld_q;
  logic [2:0][FB:0]    f_nmag_q;
  logic [2:0][PRW-1:0] f_prod_q;
  logic [2:0]          f_neg_q;
  logic [2:0][CW-1:0]  f_p1_q;
  logic [PW-1:0]       f_pen_q;
  logic                f_swap_q, f_contact_q, f_degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (adv) begin
      f_vld_q <= dv_vld[FB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        f_prod_q[i] <= h_nmag[i] * h_r1;
      end
      f_nmag_q    <= h_nmag;
      f_neg_q     <= h_neg;
      f_p1_q      <= h_p1;
      f_pen_q     <= h_pen;
      f_swap_q    <= h_swap;
      f_contact_q <= h_contact;
      f_degen_q   <= h_degen;
    end
  end

  // ---------------- stage F2: rounded offset, saturated point, packing
  logic [2:0][PRW:0]     rnd;
  logic [2:0][CW-1:0]    off;
  logic [2:0][CW+1:0]    pt_w;
  logic [2:0][CW-1:0]    pt;
  logic [2:0][NW-1:0]    nrm;
  logic [OUT_RAW-1:0]    res_raw;
  logic [SCC_USER_W-1:0] res_user;
  logic [SK_W-1:0]       res_word;
  logic [SK_W-1:0]       sk_word;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i]  = (PRW+1)'(f_prod_q[i]) + ((PRW+1)'(1) << (FB - 1));
      off[i]  = rnd[i][PRW:FB];
      pt_w[i] = f_neg_q[i] ?
                {{2{f_p1_q[i][CW-1]}}, f_p1_q[i]} + {2'b00, off[i]} :
                {{2{f_p1_q[i][CW-1]}}, f_p1_q[i]} - {2'b00, off[i]};
      if ((pt_w[i][CW+1:CW-1] == 3'b000) || (pt_w[i][CW+1:CW-1] == 3'b111)) begin
        pt[i] = pt_w[i][CW-1:0];
      end else if (pt_w[i][CW+1]) begin
        pt[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        pt[i] = {1'b0, {(CW-1){1'b1}}};
      end
      nrm[i] = f_neg_q[i] ? NW'(-{1'b0, f_nmag_q[i]}) : NW'({1'b0, f_nmag_q[i]});
    end
    if (f_contact_q) begin
      res_raw = {pt[2], pt[1], pt[0], f_pen_q, nrm[2], nrm[1], nrm[0]};
    end else begin
      res_raw = '0;
    end
    res_user                   = '0;
    res_user[SCC_USER_CONTACT] = f_contact_q;
    res_user[SCC_USER_SWAPPED] = f_swap_q;
    res_user[SCC_USER_DEGEN]   = f_contact_q & f_degen_q;
    res_word = {res_user, OUT_TW'(res_raw)};
  end

  // ---------------- output buffer
  scc_skid #(
    .W(SK_W)
  ) u_skid (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (adv & f_vld_q),
    .data_i (res_word),
    .full_o (full),
    .valid_o(m_axis_tvalid_o),
    .ready_i(m_axis_tready_i),
    .data_o (sk_word)
  );

  assign adv             = ~full;
  assign s_axis_tready_o = adv;
  assign m_axis_tdata_o  = sk_word[OUT_TW-1:0];
  assign m_axis_tuser_o  = sk_word[SK_W-1:OUT_TW];

endmodule

### rtl/core/scc_checker.sv
// Port-level checks on the contact unit's result stream
module scc_checker import scc_pkg::*; #(
  parameter int  FRAC_BITS   = SCC_FRAC_BITS,
  parameter int  COORD_WIDTH = SCC_COORD_WIDTH,
  localparam int IN_TW  = ((8 * COORD_WIDTH - 4 + 7) / 8) * 8,
  localparam int OUT_TW = ((3 * (FRAC_BITS + 2) + 4 * COORD_WIDTH - 1 + 7) / 8) * 8
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid_i,
  input logic                  s_axis_tready_o,
  input logic [IN_TW-1:0]      s_axis_tdata_i,
  input logic                  s_axis_tuser_i,
  input logic                  m_axis_tvalid_o,
  input logic                  m_axis_tready_i,
  input logic [OUT_TW-1:0]     m_axis_tdata_o,
  input logic [SCC_USER_W-1:0] m_axis_tuser_o
);

  localparam int NRM_W = 3 * (FRAC_BITS + 2);

  // a stalled result holds its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // the degenerate flag comes only with the contact flag
  a_degen_contact: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[SCC_USER_DEGEN] |->
      m_axis_tuser_o[SCC_USER_CONTACT])
    else $error("degenerate without contact");

  // no contact gives an all-zero payload
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[SCC_USER_CONTACT] |-> m_axis_tdata_o == '0)
    else $error("nonzero payload without contact");

  // degenerate transactions carry a zero normal
  a_degen_normal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[SCC_USER_DEGEN] |->
      m_axis_tdata_o[NRM_W-1:0] == '0)
    else $error("degenerate with nonzero normal");

endmodule

bind sphere_sphere_contact_unit scc_checker #(
  .FRAC_BITS  (FRAC_BITS),
  .COORD_WIDTH(COORD_WIDTH)
) u_scc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .s_axis_tdata_i (s_axis_tdata_i),
  .s_axis_tuser_i (s_axis_tuser_i),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .m_axis_tuser_o (m_axis_tuser_o)
);
